/* rtl/core/sofx_pkg.sv */
// Package for the start-of-frame / length / XOR-check frame receiver.
// Holds the byte and configuration widths, register indexes, reset values and result codes.
// No dependencies; every other file of the block uses it.
package sofx_pkg;

    localparam int unsigned BYTE_W = 8;

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_START_BYTE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CONNECT_OP  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DISCONN_OP  = 2'd3;

    localparam logic [BYTE_W-1:0] START_BYTE_RST  = 8'hA5;
    localparam logic [BYTE_W-1:0] MAX_LENGTH_RST  = 8'd241;
    localparam logic [BYTE_W-1:0] CONNECT_OP_RST  = 8'hF0;
    localparam logic [BYTE_W-1:0] DISCONN_OP_RST  = 8'hF1;

    // Result kinds
    localparam logic [1:0] KIND_OPCODE  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_END     = 2'd2;

    // Frame events reported on a good frame end
    localparam logic [1:0] EVENT_NONE       = 2'd0;
    localparam logic [1:0] EVENT_CONNECT    = 2'd1;
    localparam logic [1:0] EVENT_DISCONNECT = 2'd2;
    localparam logic [1:0] EVENT_COMMAND    = 2'd3;

endpackage

/* rtl/core/sofx_if.sv */
// Handshake channels of the frame receiver: received bytes in, results out.
// Depends on sofx_pkg for the field widths.

// Channel that carries one received byte per item.
interface sofx_rx_if;
    logic                        valid;
    logic                        ready;
    logic [sofx_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// Channel that carries one receiver result per item.
interface sofx_res_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  result_kind;
    logic [sofx_pkg::BYTE_W-1:0] data_byte;
    logic                        frame_good;
    logic [1:0]                  frame_event;
    logic [sofx_pkg::BYTE_W-1:0] payload_length;
    logic                        link_up;

    modport source (output valid, output result_kind, output data_byte, output frame_good,
                    output frame_event, output payload_length, output link_up,
                    input ready);
    modport sink   (input valid, input result_kind, input data_byte, input frame_good,
                    input frame_event, input payload_length, input link_up,
                    output ready);
endinterface

/* rtl/core/sof_length_xor_frame_receiver_unit.sv */
// Frame receiver: finds start byte, 16-bit little-endian length, opcode, payload and
// XOR check byte in a byte stream. One received byte is taken per clock cycle: every
// byte is parsed in the cycle it is accepted, and its result (opcode byte, payload
// byte or end of frame) appears in the result register on the next cycle. The only
// stall comes from the result side: a new byte is accepted whenever the result
// register is empty or is being taken in the same cycle. Header bytes, ignored bytes
// and frames dropped for a bad length produce no result. Depends on sofx_pkg and sofx_if.
module sof_length_xor_frame_receiver_unit
(
    input  logic                            clk,
    input  logic                            rst_n,
    sofx_rx_if.sink                         rx,
    sofx_res_if.source                      res,
    input  logic                            cfg_we,
    input  logic [sofx_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sofx_pkg::CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [5:0] {
        PH_WAIT   = 6'b000001,
        PH_LEN_LO = 6'b000010,
        PH_LEN_HI = 6'b000100,
        PH_OPCODE = 6'b001000,
        PH_BODY   = 6'b010000,
        PH_CHECK  = 6'b100000
    } phase_t;

    localparam int unsigned BW = sofx_pkg::BYTE_W;

    // Configuration registers
    logic [BW-1:0] start_byte_reg;
    logic [BW-1:0] max_length_reg;
    logic [BW-1:0] connect_op_reg;
    logic [BW-1:0] disconn_op_reg;

    // Parser state
    phase_t        phase_reg,     phase_next;
    logic [BW-1:0] length_reg,    length_next;
    logic [BW-1:0] count_reg,     count_next;
    logic [BW-1:0] xor_reg,       xor_next;
    logic [BW-1:0] opcode_reg,    opcode_next;
    logic          connected_reg, connected_next;

    // Result register
    logic          res_valid_reg,  res_valid_next;
    logic [1:0]    kind_reg,       kind_next;
    logic [BW-1:0] data_reg,       data_next;
    logic          good_reg,       good_next;
    logic [1:0]    event_reg,      event_next;
    logic [BW-1:0] plen_reg,       plen_next;
    logic          link_reg;

    logic          rx_fire;
    logic          emit;
    logic [BW-1:0] b;
    logic [BW-1:0] count_inc;
    logic          check_ok;

    // The byte is taken when the result slot is free or draining.
    assign rx.ready = !res_valid_reg || res.ready;
    assign rx_fire  = rx.valid && rx.ready;
    assign b        = rx.rx_byte;
    assign count_inc = count_reg + 8'd1;
    assign check_ok  = (b == xor_reg);

    // Configuration writes; indexes outside the list do not occur on a 2-bit index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg <= sofx_pkg::START_BYTE_RST;
            max_length_reg <= sofx_pkg::MAX_LENGTH_RST;
            connect_op_reg <= sofx_pkg::CONNECT_OP_RST;
            disconn_op_reg <= sofx_pkg::DISCONN_OP_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sofx_pkg::REG_START_BYTE: start_byte_reg <= cfg_data;
                sofx_pkg::REG_MAX_LENGTH: max_length_reg <= cfg_data;
                sofx_pkg::REG_CONNECT_OP: connect_op_reg <= cfg_data;
                sofx_pkg::REG_DISCONN_OP: disconn_op_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Parser: next state and result for the byte being accepted.
    always_comb
    begin
        phase_next     = phase_reg;
        length_next    = length_reg;
        count_next     = count_reg;
        xor_next       = xor_reg;
        opcode_next    = opcode_reg;
        connected_next = connected_reg;
        emit           = 1'b0;
        kind_next      = sofx_pkg::KIND_OPCODE;
        data_next      = '0;
        good_next      = 1'b0;
        event_next     = sofx_pkg::EVENT_NONE;
        plen_next      = '0;

        case (phase_reg)
            PH_LEN_LO:
            begin
                length_next = b;
                phase_next  = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                // All 16 bits count: a nonzero high byte is always too long.
                if ((b != '0) || (length_reg == '0) || (length_reg > max_length_reg))
                begin
                    phase_next = PH_WAIT;
                end
                else
                begin
                    phase_next = PH_OPCODE;
                    count_next = '0;
                end
            end
            PH_OPCODE:
            begin
                opcode_next = b;
                xor_next    = b;
                count_next  = 8'd1;
                phase_next  = (length_reg <= 8'd1) ? PH_CHECK : PH_BODY;
                emit        = 1'b1;
                kind_next   = sofx_pkg::KIND_OPCODE;
                data_next   = b;
            end
            PH_BODY:
            begin
                xor_next   = xor_reg ^ b;
                count_next = count_inc;
                if (count_inc >= length_reg)
                begin
                    phase_next = PH_CHECK;
                end
                emit      = 1'b1;
                kind_next = sofx_pkg::KIND_PAYLOAD;
                data_next = b;
            end
            PH_CHECK:
            begin
                // Connect wins when both opcodes are equal.
                if (check_ok)
                begin
                    if (opcode_reg == connect_op_reg)
                    begin
                        connected_next = 1'b1;
                        event_next     = sofx_pkg::EVENT_CONNECT;
                    end
                    else if (opcode_reg == disconn_op_reg)
                    begin
                        connected_next = 1'b0;
                        event_next     = sofx_pkg::EVENT_DISCONNECT;
                    end
                    else
                    begin
                        event_next = sofx_pkg::EVENT_COMMAND;
                    end
                end
                phase_next = PH_WAIT;
                emit       = 1'b1;
                kind_next  = sofx_pkg::KIND_END;
                good_next  = check_ok;
                plen_next  = length_reg - 8'd1;
            end
            default:
            begin
                phase_next = PH_WAIT;
                if (b == start_byte_reg)
                begin
                    phase_next = PH_LEN_LO;
                    count_next = '0;
                end
            end
        endcase
    end

    // Parser state registers advance only on an accepted byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_WAIT;
            length_reg    <= '0;
            count_reg     <= '0;
            xor_reg       <= '0;
            opcode_reg    <= '0;
            connected_reg <= 1'b0;
        end
        else if (rx_fire)
        begin
            phase_reg     <= phase_next;
            length_reg    <= length_next;
            count_reg     <= count_next;
            xor_reg       <= xor_next;
            opcode_reg    <= opcode_next;
            connected_reg <= connected_next;
        end
    end

    // Result register valid: loaded by a byte that gives a result, cleared when taken.
    assign res_valid_next = rx_fire ? emit : (res_valid_reg && !res.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (rx_fire && emit)
        begin
            kind_reg  <= kind_next;
            data_reg  <= data_next;
            good_reg  <= good_next;
            event_reg <= event_next;
            plen_reg  <= plen_next;
            link_reg  <= connected_next;
        end
    end

    assign res.valid          = res_valid_reg;
    assign res.result_kind    = kind_reg;
    assign res.data_byte      = data_reg;
    assign res.frame_good     = good_reg;
    assign res.frame_event    = event_reg;
    assign res.payload_length = plen_reg;
    assign res.link_up        = link_reg;

`ifndef NO_ASSERTIONS
    // Byte results carry no end-of-frame information.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && (res.result_kind != sofx_pkg::KIND_END)) |->
        (!res.frame_good && (res.frame_event == sofx_pkg::EVENT_NONE)
         && (res.payload_length == '0)))
    else $error("byte result carries frame end fields");

    // The link flag only changes on an accepted check byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (connected_reg != $past(connected_reg)) |->
        ($past(rx_fire) && ($past(phase_reg) == PH_CHECK)))
    else $error("link flag changed outside a frame end");

    // The body count stays below the frame length while payload is expected.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_BODY) |-> (count_reg < length_reg))
    else $error("body count reached frame length in body phase");
`endif

endmodule

/* bench/testbench.sv */
// Self-checking bench for the start-of-frame / length / XOR-check frame receiver.
// Drives directed and random byte streams, takes each expected result from a table or its model and compares it.
// Depends on sofx_pkg, sofx_if and sof_length_xor_frame_receiver_unit.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned STALL_LIMIT   = 2000;

    // One result item of the receiver
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       good;
        logic [1:0] ev;
        logic [7:0] plen;
        logic       link;
    } frame_result_t;

    // One row of the directed stimulus table
    typedef struct {
        logic [7:0]    b;
        bit            typed;
        bit            has_res;
        frame_result_t r;
    } stim_row_t;

    typedef enum logic [2:0] {
        PH_WAIT, PH_LEN_LO, PH_LEN_HI, PH_OPCODE, PH_BODY, PH_CHECK
    } parse_phase_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [sofx_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [sofx_pkg::CFG_DATA_W-1:0] cfg_data;

    sofx_rx_if  rx_ch ();
    sofx_res_if res_ch ();

    sof_length_xor_frame_receiver_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx_ch),
        .res       (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Register copies held by the bench
    logic [7:0] cfg_start;
    logic [7:0] cfg_max;
    logic [7:0] cfg_conn;
    logic [7:0] cfg_disc;

    // Parser state of the bench's own receiver model
    parse_phase_t rx_phase;
    logic [15:0]  frame_len;
    logic [7:0]   body_cnt;
    logic [7:0]   body_xor;
    logic [7:0]   frame_op;
    logic         link_flag;

    frame_result_t expected_q[$];
    stim_row_t     directed_q[$];
    int unsigned   fail_count;
    int unsigned   src_idle_pct;
    int unsigned   snk_stall_pct;
    int unsigned   phase_items;
    int unsigned   idle_cycles;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Advances the receiver model by one byte; returns 1 when a result is due.
    function automatic bit decode_byte(input logic [7:0] b, output frame_result_t r);
        bit has;
        has = 1'b0;
        r = '0;
        case (rx_phase)
            PH_LEN_LO:
            begin
                frame_len = {8'd0, b};
                rx_phase = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                frame_len[15:8] = b;
                if (frame_len == 16'd0 || frame_len > {8'd0, cfg_max})
                    rx_phase = PH_WAIT;
                else
                begin
                    rx_phase = PH_OPCODE;
                    body_cnt = 8'd0;
                end
            end
            PH_OPCODE:
            begin
                frame_op = b;
                body_xor = b;
                body_cnt = 8'd1;
                rx_phase = ({8'd0, body_cnt} >= frame_len) ? PH_CHECK : PH_BODY;
                r.kind = sofx_pkg::KIND_OPCODE;
                r.data = b;
                has = 1'b1;
            end
            PH_BODY:
            begin
                body_xor = body_xor ^ b;
                body_cnt = body_cnt + 8'd1;
                if ({8'd0, body_cnt} >= frame_len)
                    rx_phase = PH_CHECK;
                r.kind = sofx_pkg::KIND_PAYLOAD;
                r.data = b;
                has = 1'b1;
            end
            PH_CHECK:
            begin
                r.kind = sofx_pkg::KIND_END;
                r.good = (b == body_xor);
                r.ev = sofx_pkg::EVENT_NONE;
                if (r.good)
                begin
                    // Connect wins when both opcodes are equal.
                    if (frame_op == cfg_conn)
                    begin
                        link_flag = 1'b1;
                        r.ev = sofx_pkg::EVENT_CONNECT;
                    end
                    else if (frame_op == cfg_disc)
                    begin
                        link_flag = 1'b0;
                        r.ev = sofx_pkg::EVENT_DISCONNECT;
                    end
                    else
                        r.ev = sofx_pkg::EVENT_COMMAND;
                end
                r.plen = frame_len[7:0] - 8'd1;
                rx_phase = PH_WAIT;
                has = 1'b1;
            end
            default:
            begin
                rx_phase = PH_WAIT;
                if (b == cfg_start)
                begin
                    rx_phase = PH_LEN_LO;
                    body_cnt = 8'd0;
                end
            end
        endcase
        r.link = link_flag;
        return has;
    endfunction

    function automatic frame_result_t make_result(input logic [1:0] kind, input logic [7:0] data,
                                                  input logic good, input logic [1:0] ev,
                                                  input logic [7:0] plen, input logic link);
        frame_result_t r;
        r.kind = kind;
        r.data = data;
        r.good = good;
        r.ev   = ev;
        r.plen = plen;
        r.link = link;
        return r;
    endfunction

    function automatic void add_row(input logic [7:0] b, input bit typed, input bit has_res,
                                    input frame_result_t r);
        stim_row_t row;
        row.b = b;
        row.typed = typed;
        row.has_res = has_res;
        row.r = r;
        directed_q.push_back(row);
    endfunction

    // Sends one byte; the expectation is queued in the cycle it is accepted.
    // Called and returning at a rising edge.
    task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                             input bit typed_has = 1'b0, input frame_result_t typed_r = '0);
        frame_result_t predicted;
        bit has;
        while ($urandom_range(99) < src_idle_pct)
        begin
            rx_ch.valid <= 1'b0;
            @(posedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        @(negedge clk);
        while (!rx_ch.ready)
            @(negedge clk);
        has = decode_byte(b, predicted);
        if (typed)
        begin
            if (typed_has)
                expected_q.push_back(typed_r);
        end
        else if (has)
            expected_q.push_back(predicted);
        @(posedge clk);
    endtask

    // Stops sending and waits until every expected result has come.
    task automatic drain_results();
        rx_ch.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes all four registers while the receiver is idle.
    task automatic load_settings(input logic [7:0] start_v, input logic [7:0] max_v,
                                 input logic [7:0] conn_v, input logic [7:0] disc_v);
        logic [7:0] vals[4];
        vals[0] = start_v;
        vals[1] = max_v;
        vals[2] = conn_v;
        vals[3] = disc_v;
        drain_results();
        for (int i = 0; i < 4; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= i[sofx_pkg::CFG_IDX_W-1:0];
            cfg_data  <= vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        cfg_start = start_v;
        cfg_max   = max_v;
        cfg_conn  = conn_v;
        cfg_disc  = disc_v;
    endtask

    // Sends one frame with random content; some are dropped, broken or carry a bad check.
    task automatic send_frame();
        int unsigned pick;
        int unsigned body_n;
        bit          broken;
        logic [15:0] len;
        logic [7:0]  op;
        logic [7:0]  b;
        logic [7:0]  sum;
        pick = $urandom_range(99);
        if (pick < 70)
            len = 16'($urandom_range(1, (cfg_max < 8) ? cfg_max : 8));
        else if (pick < 80)
            len = {8'd0, cfg_max};
        else if (pick < 86)
            len = 16'($urandom_range(1, cfg_max));
        else if (pick < 90)
            len = 16'd0;
        else if (pick < 95 && cfg_max < 8'd255)
            len = 16'($urandom_range(cfg_max + 1, 255));
        else
            len = 16'($urandom_range(256, 65535));
        send_byte(cfg_start);
        send_byte(len[7:0]);
        send_byte(len[15:8]);
        phase_items += 3;
        if (len == 16'd0 || len > {8'd0, cfg_max})
            return;

        pick = $urandom_range(99);
        if (pick < 30)
            op = cfg_conn;
        else if (pick < 60)
            op = cfg_disc;
        else
            op = 8'($urandom_range(255));

        broken = ($urandom_range(99) < 5);
        body_n = broken ? $urandom_range(0, len) : len;
        sum = 8'd0;
        for (int unsigned i = 0; i < body_n; i++)
        begin
            b = (i == 0) ? op : 8'($urandom_range(255));
            sum ^= b;
            send_byte(b);
            phase_items++;
        end
        if (!broken)
        begin
            b = ($urandom_range(99) < 85) ? sum : sum ^ 8'($urandom_range(1, 255));
            send_byte(b);
            phase_items++;
        end
    endtask

    // Random traffic: mostly frames, with some stray bytes between them.
    task automatic run_random(input int unsigned target, input int unsigned src_pct,
                              input int unsigned snk_pct, input bit mid_pause);
        int unsigned n;
        bit paused;
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        phase_items   = 0;
        paused        = 1'b0;
        while (phase_items < target)
        begin
            if ($urandom_range(99) < 8)
            begin
                n = $urandom_range(1, 3);
                repeat (n) send_byte(8'($urandom_range(255)));
            end
            send_frame();
            if (mid_pause && !paused && phase_items >= target / 2)
            begin
                drain_results();
                paused = 1'b1;
            end
        end
    endtask

    // Result checker: a result is taken at the edge after a low clock phase
    // in which valid and ready are both high.
    initial
    begin
        frame_result_t want;
        frame_result_t got;
        forever
        begin
            @(negedge clk);
            if (rst_n && res_ch.valid && res_ch.ready)
            begin
                got = {res_ch.result_kind, res_ch.data_byte, res_ch.frame_good,
                       res_ch.frame_event, res_ch.payload_length, res_ch.link_up};
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                    fail_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: result mismatch, expected %h, actual %h",
                                 $time, want, got);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Result side stalls at random.
    initial
    begin
        res_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            res_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // Watchdog: ends the run when nothing moves on either channel for too long.
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(negedge clk);
            if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    // Main sequence
    initial
    begin
        rst_n         = 1'b0;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = 8'd0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        fail_count    = 0;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        cfg_start     = sofx_pkg::START_BYTE_RST;
        cfg_max       = sofx_pkg::MAX_LENGTH_RST;
        cfg_conn      = sofx_pkg::CONNECT_OP_RST;
        cfg_disc      = sofx_pkg::DISCONN_OP_RST;
        rx_phase      = PH_WAIT;
        frame_len     = 16'd0;
        body_cnt      = 8'd0;
        body_xor      = 8'd0;
        frame_op      = 8'd0;
        link_flag     = 1'b0;

        // Connect frame of length one, with the reset register values
        add_row(8'hA5, 1'b1, 1'b0, '0);
        add_row(8'h01, 1'b1, 1'b0, '0);
        add_row(8'h00, 1'b1, 1'b0, '0);
        add_row(8'hF0, 1'b1, 1'b1, make_result(sofx_pkg::KIND_OPCODE, 8'hF0, 1'b0,
                                               sofx_pkg::EVENT_NONE, 8'd0, 1'b0));
        add_row(8'hF0, 1'b1, 1'b1, make_result(sofx_pkg::KIND_END, 8'h00, 1'b1,
                                               sofx_pkg::EVENT_CONNECT, 8'd0, 1'b1));
        // Wrong check byte: bad end, link flag kept
        add_row(8'hA5, 1'b1, 1'b0, '0);
        add_row(8'h01, 1'b1, 1'b0, '0);
        add_row(8'h00, 1'b1, 1'b0, '0);
        add_row(8'h37, 1'b1, 1'b1, make_result(sofx_pkg::KIND_OPCODE, 8'h37, 1'b0,
                                               sofx_pkg::EVENT_NONE, 8'd0, 1'b1));
        add_row(8'h00, 1'b1, 1'b1, make_result(sofx_pkg::KIND_END, 8'h00, 1'b0,
                                               sofx_pkg::EVENT_NONE, 8'd0, 1'b1));
        // Zero length is dropped silently
        add_row(8'hA5, 1'b1, 1'b0, '0);
        add_row(8'h00, 1'b1, 1'b0, '0);
        add_row(8'h00, 1'b1, 1'b0, '0);
        // Length above the limit only through its high byte
        add_row(8'hA5, 1'b1, 1'b0, '0);
        add_row(8'hF1, 1'b1, 1'b0, '0);
        add_row(8'h01, 1'b1, 1'b0, '0);
        // Disconnect frame
        add_row(8'hA5, 1'b1, 1'b0, '0);
        add_row(8'h01, 1'b1, 1'b0, '0);
        add_row(8'h00, 1'b1, 1'b0, '0);
        add_row(8'hF1, 1'b1, 1'b1, make_result(sofx_pkg::KIND_OPCODE, 8'hF1, 1'b0,
                                               sofx_pkg::EVENT_NONE, 8'd0, 1'b1));
        add_row(8'hF1, 1'b1, 1'b1, make_result(sofx_pkg::KIND_END, 8'h00, 1'b1,
                                               sofx_pkg::EVENT_DISCONNECT, 8'd0, 1'b0));
        // Command frame with two payload bytes, checked by the model
        add_row(8'hA5, 1'b0, 1'b0, '0);
        add_row(8'h03, 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b0, '0);
        add_row(8'hFF, 1'b0, 1'b0, '0);
        add_row(8'h80, 1'b0, 1'b0, '0);
        add_row(8'h7F, 1'b0, 1'b0, '0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_q[i])
            send_byte(directed_q[i].b, directed_q[i].typed, directed_q[i].has_res,
                      directed_q[i].r);

        // Extremes of the registers, then random settings, with each idling mix
        load_settings(8'h00, 8'd255, 8'h00, 8'hFF);
        run_random(160, 0, 0, 1'b0);
        load_settings(8'hFF, 8'd1, 8'h55, 8'hAA);
        run_random(150, 46, 0, 1'b0);
        load_settings(8'h7E, 8'd12, 8'h33, 8'h33);
        run_random(160, 0, 46, 1'b0);
        load_settings(8'($urandom_range(255)), 8'($urandom_range(1, 40)),
                      8'($urandom_range(255)), 8'($urandom_range(255)));
        run_random(160, 22, 22, 1'b0);
        load_settings(sofx_pkg::START_BYTE_RST, sofx_pkg::MAX_LENGTH_RST,
                      sofx_pkg::CONNECT_OP_RST, sofx_pkg::DISCONN_OP_RST);
        run_random(150, 0, 0, 1'b1);
        load_settings(8'($urandom_range(255)), 8'($urandom_range(1, 20)),
                      8'($urandom_range(255)), 8'($urandom_range(255)));
        run_random(140, 46, 46, 1'b0);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
